### hw/rtl/vtpg_pkg.sv
// Shared types, constants and register indexes of the video test pattern generator.
package vtpg_pkg;

    // Fixed field widths
    localparam int INTENSITY_W = 8;
    localparam int COORD_W     = 11;
    localparam int SIZE_W      = 12;
    localparam int STEP_W      = 25;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 25;

    // Parameter defaults
    localparam int MAX_WIDTH_DEFAULT     = 2048;
    localparam int MAX_HEIGHT_DEFAULT    = 2048;
    localparam int FRACTION_BITS_DEFAULT = 16;

    // Register reset values
    localparam logic              PATTERN_RESET      = 1'b1;
    localparam logic [SIZE_W-1:0] FRAME_WIDTH_RESET  = 12'd1280;
    localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RESET = 12'd720;
    localparam logic [STEP_W-1:0] COLUMN_STEP_RESET  = 25'd3407872;
    localparam logic [STEP_W-1:0] ROW_STEP_RESET     = 25'd46603;

    // Bar sequencing
    localparam logic [3:0] BAR_FIRST = 4'd1;
    localparam logic [3:0] BAR_LAST  = 4'd7;
    localparam logic [3:0] BAR_MAX   = 4'd15;

    localparam logic [INTENSITY_W-1:0] INTENSITY_FULL = 8'd255;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_SELECT = 3'd0,
        REG_FRAME_WIDTH    = 3'd1,
        REG_FRAME_HEIGHT   = 3'd2,
        REG_COLUMN_STEP    = 3'd3,
        REG_ROW_STEP       = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic              pattern_select;
        logic [SIZE_W-1:0] frame_width;
        logic [SIZE_W-1:0] frame_height;
        logic [STEP_W-1:0] column_step;
        logic [STEP_W-1:0] row_step;
    } cfg_t;

    typedef struct packed {
        logic [INTENSITY_W-1:0] red_value;
        logic [INTENSITY_W-1:0] blue_value;
        logic [INTENSITY_W-1:0] green_value;
        logic [COORD_W-1:0]     pixel_column;
        logic [COORD_W-1:0]     pixel_row;
        logic                   end_of_line;
        logic                   end_of_frame;
    } pixel_t;

endpackage

### hw/rtl/vtpg_req_if.sv
// Request channel interface: one frame-restart flag per pixel request.
interface vtpg_req_if;
    logic valid;
    logic ready;
    logic restart_frame;

    modport source (output valid, output restart_frame, input ready);
    modport sink   (input valid, input restart_frame, output ready);
endinterface

### hw/rtl/vtpg_pix_if.sv
// Pixel channel interface: color, position and line/frame markers of one pixel.
interface vtpg_pix_if;
    logic                                 valid;
    logic                                 ready;
    logic [vtpg_pkg::INTENSITY_W-1:0]     red_value;
    logic [vtpg_pkg::INTENSITY_W-1:0]     blue_value;
    logic [vtpg_pkg::INTENSITY_W-1:0]     green_value;
    logic [vtpg_pkg::COORD_W-1:0]         pixel_column;
    logic [vtpg_pkg::COORD_W-1:0]         pixel_row;
    logic                                 end_of_line;
    logic                                 end_of_frame;

    modport source (output valid, output red_value, output blue_value, output green_value,
                    output pixel_column, output pixel_row, output end_of_line,
                    output end_of_frame, input ready);
    modport sink   (input valid, input red_value, input blue_value, input green_value,
                    input pixel_column, input pixel_row, input end_of_line,
                    input end_of_frame, output ready);
endinterface

### hw/rtl/vtpg_acc_step.sv
// Saturating add or subtract of an unsigned step to a signed fixed-point accumulator.
module vtpg_acc_step #(
    parameter int ACC_W  = 26,
    parameter int STEP_W = 25
) (
    input  logic signed [ACC_W-1:0]  acc,
    input  logic        [STEP_W-1:0] step,
    input  logic                     subtract,
    output logic signed [ACC_W-1:0]  result
);
    localparam int SUM_W = ((ACC_W > STEP_W) ? ACC_W : STEP_W) + 2;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic signed [SUM_W-1:0] acc_ext;
    logic signed [SUM_W-1:0] step_ext;
    logic signed [SUM_W-1:0] sum;

    always_comb
    begin
        acc_ext  = SUM_W'(acc);
        step_ext = SUM_W'($signed({1'b0, step}));
        sum      = subtract ? (acc_ext - step_ext) : (acc_ext + step_ext);
        // clamp to the accumulator range
        if (sum > SUM_W'(ACC_MAX))
        begin
            result = ACC_MAX;
        end
        else if (sum < SUM_W'(ACC_MIN))
        begin
            result = ACC_MIN;
        end
        else
        begin
            result = ACC_W'(sum);
        end
    end
endmodule

### hw/rtl/vtpg_pixel_core.sv
// Raster counters, ramp accumulators and color selection for the current pixel.
module vtpg_pixel_core #(
    parameter int MAX_WIDTH     = vtpg_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT    = vtpg_pkg::MAX_HEIGHT_DEFAULT,
    parameter int FRACTION_BITS = vtpg_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  vtpg_pkg::cfg_t   cfg,
    input  logic             advance,
    input  logic             restart,
    output vtpg_pkg::pixel_t pixel
);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1) + 1;
    localparam int HW    = $clog2(MAX_HEIGHT + 1) + 1;
    localparam int ACC_W = FRACTION_BITS + 10;
    localparam int SZ_W  = vtpg_pkg::SIZE_W + 1;

    localparam logic signed [ACC_W-1:0] FULL_SCALE = {2'b01, {(FRACTION_BITS+8){1'b0}}};
    localparam logic [SZ_W-1:0] MAX_W_CFG = SZ_W'(MAX_WIDTH);
    localparam logic [SZ_W-1:0] MAX_H_CFG = SZ_W'(MAX_HEIGHT);

    function automatic logic [vtpg_pkg::INTENSITY_W-1:0] to_intensity(
        input logic signed [ACC_W-1:0] v
    );
        logic [vtpg_pkg::INTENSITY_W-1:0] res;
        if (v[ACC_W-1])
        begin
            res = '0;
        end
        else if (v >= FULL_SCALE)
        begin
            res = vtpg_pkg::INTENSITY_FULL;
        end
        else
        begin
            res = v[FRACTION_BITS +: vtpg_pkg::INTENSITY_W];
        end
        return res;
    endfunction

    logic [CW-1:0]             col_reg, col_next, col_cur;
    logic [RW-1:0]             row_reg, row_next, row_cur;
    logic signed [ACC_W-1:0]   red_reg, red_next, red_cur, red_adj;
    logic signed [ACC_W-1:0]   blue_reg, blue_next, blue_cur, blue_adj;
    logic signed [ACC_W-1:0]   bar_reg, bar_next, bar_cur, bar_adj;
    logic signed [ACC_W-1:0]   green_reg, green_next, green_cur, green_adj;
    logic [3:0]                interval_reg, interval_next, interval_cur;

    logic [WW-1:0] w_eff, col_ext, col_inc, q1, q2, q3;
    logic [HW-1:0] h_eff, row_ext, row_inc, half_h;
    logic          eol, eof;
    logic          in_q1, in_q3, red_sub, green_sub;
    logic [vtpg_pkg::INTENSITY_W-1:0] bar_int;

    // clamp the configured size into the supported range
    always_comb
    begin
        if (cfg.frame_width == '0)
        begin
            w_eff = WW'(1);
        end
        else if ({1'b0, cfg.frame_width} > MAX_W_CFG)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(cfg.frame_width);
        end

        if (cfg.frame_height == '0)
        begin
            h_eff = HW'(1);
        end
        else if ({1'b0, cfg.frame_height} > MAX_H_CFG)
        begin
            h_eff = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HW'(cfg.frame_height);
        end
    end

    // restart request takes effect before this pixel is produced
    always_comb
    begin
        col_cur      = restart ? '0 : col_reg;
        row_cur      = restart ? '0 : row_reg;
        red_cur      = restart ? FULL_SCALE : red_reg;
        blue_cur     = restart ? '0 : blue_reg;
        bar_cur      = restart ? '0 : bar_reg;
        green_cur    = restart ? '0 : green_reg;
        interval_cur = restart ? vtpg_pkg::BAR_FIRST : interval_reg;
    end

    always_comb
    begin
        col_ext   = WW'(col_cur);
        col_inc   = col_ext + WW'(1);
        row_ext   = HW'(row_cur);
        row_inc   = row_ext + HW'(1);
        eol       = (col_inc >= w_eff);
        eof       = eol && (row_inc >= h_eff);
        q1        = w_eff >> 2;
        q2        = q1 << 1;
        q3        = q1 + q2;
        half_h    = h_eff >> 1;
        in_q1     = (col_ext < q1);
        in_q3     = !in_q1 && !(col_ext < q2) && (col_ext < q3);
        red_sub   = in_q1 || in_q3;
        green_sub = !(row_ext < half_h);
    end

    vtpg_acc_step #(.ACC_W(ACC_W), .STEP_W(vtpg_pkg::STEP_W)) u_red_step (
        .acc(red_cur), .step(cfg.column_step), .subtract(red_sub), .result(red_adj)
    );
    vtpg_acc_step #(.ACC_W(ACC_W), .STEP_W(vtpg_pkg::STEP_W)) u_blue_step (
        .acc(blue_cur), .step(cfg.column_step), .subtract(in_q3), .result(blue_adj)
    );
    vtpg_acc_step #(.ACC_W(ACC_W), .STEP_W(vtpg_pkg::STEP_W)) u_bar_step (
        .acc(bar_cur), .step(cfg.column_step), .subtract(1'b0), .result(bar_adj)
    );
    vtpg_acc_step #(.ACC_W(ACC_W), .STEP_W(vtpg_pkg::STEP_W)) u_green_step (
        .acc(green_cur), .step(cfg.row_step), .subtract(green_sub), .result(green_adj)
    );

    // pixel color and position
    always_comb
    begin
        bar_int = to_intensity(bar_cur);
        if (!cfg.pattern_select)
        begin
            pixel.red_value   = to_intensity(red_cur);
            pixel.blue_value  = to_intensity(blue_cur);
            pixel.green_value = to_intensity(green_cur);
        end
        else if (interval_cur > vtpg_pkg::BAR_LAST)
        begin
            pixel.red_value   = vtpg_pkg::INTENSITY_FULL;
            pixel.blue_value  = vtpg_pkg::INTENSITY_FULL;
            pixel.green_value = vtpg_pkg::INTENSITY_FULL;
        end
        else
        begin
            // bar number bits enable red, blue and green in that order
            pixel.red_value   = interval_cur[0] ? bar_int : '0;
            pixel.blue_value  = interval_cur[1] ? bar_int : '0;
            pixel.green_value = interval_cur[2] ? bar_int : '0;
        end
        pixel.pixel_column = vtpg_pkg::COORD_W'(col_cur);
        pixel.pixel_row    = vtpg_pkg::COORD_W'(row_cur);
        pixel.end_of_line  = eol;
        pixel.end_of_frame = eof;
    end

    // state after this pixel
    always_comb
    begin
        col_next      = CW'(col_inc);
        row_next      = row_cur;
        red_next      = red_cur;
        blue_next     = blue_cur;
        bar_next      = bar_cur;
        green_next    = green_cur;
        interval_next = interval_cur;
        if (eof)
        begin
            col_next      = '0;
            row_next      = '0;
            red_next      = FULL_SCALE;
            blue_next     = '0;
            bar_next      = '0;
            green_next    = '0;
            interval_next = vtpg_pkg::BAR_FIRST;
        end
        else if (eol)
        begin
            col_next      = '0;
            row_next      = RW'(row_inc);
            red_next      = FULL_SCALE;
            blue_next     = '0;
            bar_next      = '0;
            green_next    = green_adj;
            interval_next = vtpg_pkg::BAR_FIRST;
        end
        else
        begin
            red_next  = (col_ext < q3) ? red_adj : '0;
            blue_next = in_q1 ? '0 : blue_adj;
            if (bar_adj >= FULL_SCALE)
            begin
                bar_next = '0;
                if (interval_cur < vtpg_pkg::BAR_MAX)
                begin
                    interval_next = interval_cur + 4'd1;
                end
            end
            else
            begin
                bar_next = bar_adj;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            red_reg      <= FULL_SCALE;
            blue_reg     <= '0;
            bar_reg      <= '0;
            green_reg    <= '0;
            interval_reg <= vtpg_pkg::BAR_FIRST;
        end
        else if (advance)
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            red_reg      <= red_next;
            blue_reg     <= blue_next;
            bar_reg      <= bar_next;
            green_reg    <= green_next;
            interval_reg <= interval_next;
        end
    end
endmodule

### hw/rtl/video_test_pattern_generator.sv
// Top level of the video test pattern generator: config registers and pixel output stage.
//
//  Channel  Dir  Payload                                         Accept
//  req      in   restart_frame                                   req.valid & req.ready
//  pix      out  red/blue/green_value, pixel_column/row, eol/eof pix.valid & pix.ready
//  cfg      in   cfg_index, cfg_data                             cfg_write
//
//  One pixel per clock unless pix stalls: each request produces its pixel in the output
//  register in the cycle after acceptance; the raster counters and ramp accumulators
//  update in the same edge. A new request is taken whenever the output register is
//  empty or being drained, so stalls on pix backpressure req only for the cycles they
//  last. Reset (rst_n, async, active low) loads the register defaults and parks the
//  raster at pixel zero of a new frame with an empty output register.
module video_test_pattern_generator #(
    parameter int MAX_WIDTH     = vtpg_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT    = vtpg_pkg::MAX_HEIGHT_DEFAULT,
    parameter int FRACTION_BITS = vtpg_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [vtpg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [vtpg_pkg::CFG_DATA_W-1:0]    cfg_data,
    vtpg_req_if.sink                           req,
    vtpg_pix_if.source                         pix
);
    vtpg_pkg::cfg_t   cfg_reg;
    vtpg_pkg::pixel_t core_pixel;
    vtpg_pkg::pixel_t pixel_reg;
    logic             out_valid_reg;
    logic             accept;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_select <= vtpg_pkg::PATTERN_RESET;
            cfg_reg.frame_width    <= vtpg_pkg::FRAME_WIDTH_RESET;
            cfg_reg.frame_height   <= vtpg_pkg::FRAME_HEIGHT_RESET;
            cfg_reg.column_step    <= vtpg_pkg::COLUMN_STEP_RESET;
            cfg_reg.row_step       <= vtpg_pkg::ROW_STEP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (vtpg_pkg::cfg_index_t'(cfg_index))
                vtpg_pkg::REG_PATTERN_SELECT:
                    cfg_reg.pattern_select <= cfg_data[0];
                vtpg_pkg::REG_FRAME_WIDTH:
                    cfg_reg.frame_width <= cfg_data[vtpg_pkg::SIZE_W-1:0];
                vtpg_pkg::REG_FRAME_HEIGHT:
                    cfg_reg.frame_height <= cfg_data[vtpg_pkg::SIZE_W-1:0];
                vtpg_pkg::REG_COLUMN_STEP:
                    cfg_reg.column_step <= cfg_data[vtpg_pkg::STEP_W-1:0];
                vtpg_pkg::REG_ROW_STEP:
                    cfg_reg.row_step <= cfg_data[vtpg_pkg::STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Take a request whenever the output register is empty or frees up this cycle.
    assign req.ready = !out_valid_reg || pix.ready;
    assign accept    = req.valid && req.ready;

    vtpg_pixel_core #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .advance(accept),
        .restart(req.restart_frame),
        .pixel  (core_pixel)
    );

    // Output valid flag: set on a new pixel, clear once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pix.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the pixel payload until the next accepted request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pixel_reg <= core_pixel;
        end
    end

    assign pix.valid        = out_valid_reg;
    assign pix.red_value    = pixel_reg.red_value;
    assign pix.blue_value   = pixel_reg.blue_value;
    assign pix.green_value  = pixel_reg.green_value;
    assign pix.pixel_column = pixel_reg.pixel_column;
    assign pix.pixel_row    = pixel_reg.pixel_row;
    assign pix.end_of_line  = pixel_reg.end_of_line;
    assign pix.end_of_frame = pixel_reg.end_of_frame;
endmodule
